>>> rtl/class_file_stream_parser_assert.svh
// assertion macros for the class file stream parser checker
`ifndef CLASS_FILE_STREAM_PARSER_ASSERT_SVH
`define CLASS_FILE_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CFSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CFSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cfsp_pkg.sv
// types, codes and tables for the class file stream parser
package cfsp_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFE_BABE;
    localparam logic [7:0]  MAX_TAG    = 8'd20;
    localparam logic [31:0] MIN_POOL   = 32'd2;

    // constant pool tags with special handling
    localparam logic [4:0] TAG_UTF8    = 5'd1;
    localparam logic [4:0] TAG_INTEGER = 5'd3;
    localparam logic [4:0] TAG_FLOAT   = 5'd4;
    localparam logic [4:0] TAG_LONG    = 5'd5;
    localparam logic [4:0] TAG_DOUBLE  = 5'd6;
    localparam logic [4:0] TAG_MHANDLE = 5'd15;

    // parse phases; attribute groups keep name, length, body in a row
    typedef enum logic [4:0] {
        PH_MAGIC = 5'd0,
        PH_HDR,
        PH_TAG,
        PH_PFIELD,
        PH_PBODY,
        PH_CINFO,
        PH_ICOUNT,
        PH_IFACE,
        PH_FCOUNT,
        PH_FHDR,
        PH_FANAME,
        PH_FALEN,
        PH_FABODY,
        PH_MCOUNT,
        PH_MHDR,
        PH_MANAME,
        PH_MALEN,
        PH_MABODY,
        PH_CCOUNT,
        PH_CANAME,
        PH_CALEN,
        PH_CABODY,
        PH_DONE
    } cfsp_phase_t;

    typedef enum logic [2:0] {
        SEC_HEADER     = 3'd0,
        SEC_POOL       = 3'd1,
        SEC_CLASS_INFO = 3'd2,
        SEC_IFACES     = 3'd3,
        SEC_FIELDS     = 3'd4,
        SEC_METHODS    = 3'd5,
        SEC_CLASS_ATTR = 3'd6
    } cfsp_section_t;

    typedef enum logic [2:0] {
        KIND_COUNT  = 3'd0,
        KIND_TAG    = 3'd1,
        KIND_U1     = 3'd2,
        KIND_U2     = 3'd3,
        KIND_U4     = 3'd4,
        KIND_LENGTH = 3'd5,
        KIND_RAW    = 3'd6,
        KIND_ERROR  = 3'd7
    } cfsp_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_POOL_SMALL = 2'd2,
        ST_BAD_TAG   = 2'd3
    } cfsp_status_t;

    typedef struct packed {
        cfsp_phase_t phase;
        logic [2:0]  byte_in_field;
        logic [31:0] accumulator;
        logic [15:0] pool_slot;
        logic [15:0] pool_total;
        logic [4:0]  current_tag;
        logic [31:0] bytes_remaining;
        logic [15:0] member_number;
        logic [15:0] member_total;
        logic [15:0] attr_number;
        logic [15:0] attr_total;
        logic        stopped;
    } cfsp_state_t;

    localparam cfsp_state_t STATE_RESET = '{
        phase:           PH_MAGIC,
        byte_in_field:   3'd0,
        accumulator:     32'd0,
        pool_slot:       16'd0,
        pool_total:      16'd0,
        current_tag:     5'd0,
        bytes_remaining: 32'd0,
        member_number:   16'd0,
        member_total:    16'd0,
        attr_number:     16'd0,
        attr_total:      16'd0,
        stopped:         1'b0
    };

    typedef struct packed {
        cfsp_section_t section;
        cfsp_kind_t    kind;
        logic [1:0]    position;
        logic [31:0]   value;
        logic [15:0]   entry_index;
        logic [15:0]   attr_index;
        cfsp_status_t  status;
        logic          done_res;
    } cfsp_record_t;

    // fields after a pool tag; zero means the tag has no handler
    function automatic logic [1:0] tag_field_count(input logic [7:0] tag);
        logic [1:0] cnt;
        case (tag)
            8'd1, 8'd3, 8'd4, 8'd7, 8'd8, 8'd16, 8'd19, 8'd20:
                cnt = 2'd1;
            8'd5, 8'd6, 8'd9, 8'd10, 8'd11, 8'd12, 8'd15, 8'd17, 8'd18:
                cnt = 2'd2;
            default:
                cnt = 2'd0;
        endcase
        return cnt;
    endfunction

endpackage

>>> rtl/cfsp_if.sv
// byte stream and record stream channels of the class file parser

interface cfsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface cfsp_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  section;
    logic [2:0]  kind;
    logic [1:0]  position;
    logic [31:0] value;
    logic [15:0] entry_index;
    logic [15:0] attr_index;
    logic [1:0]  status;
    logic        done_res;

    modport source (
        output valid, output section, output kind, output position, output value,
        output entry_index, output attr_index, output status, output done_res,
        input  ready
    );
    modport sink (
        input  valid, input section, input kind, input position, input value,
        input  entry_index, input attr_index, input status, input done_res,
        output ready
    );
endinterface

>>> rtl/cfsp_step.sv
// one parser step: next state and optional record for one input byte
module cfsp_step (
    input  cfsp_pkg::cfsp_state_t  state,
    input  logic [7:0]             data_byte,
    output cfsp_pkg::cfsp_state_t  state_next,
    output logic                   rec_valid,
    output cfsp_pkg::cfsp_record_t rec
);
    import cfsp_pkg::*;

    logic [2:0]    width;
    logic [2:0]    count_inc;
    logic [31:0]   word;
    logic          complete;
    logic          active;
    logic [15:0]   member_inc;
    logic [15:0]   attr_inc;
    logic [31:0]   rem_dec;
    logic [16:0]   slot_step;
    logic          pool_end;
    logic [1:0]    tag_cnt;
    logic [1:0]    cur_tag_cnt;
    cfsp_phase_t   a_base;
    cfsp_phase_t   a_hdr;
    cfsp_phase_t   a_next_count;
    cfsp_section_t a_sec;
    logic          a_class;

    // width of the field being collected
    always_comb
    begin
        unique case (state.phase) inside
            PH_MAGIC, PH_FALEN, PH_MALEN, PH_CALEN:
                width = 3'd4;
            PH_TAG, PH_PBODY, PH_FABODY, PH_MABODY, PH_CABODY:
                width = 3'd1;
            PH_PFIELD:
            begin
                if (state.current_tag == TAG_INTEGER || state.current_tag == TAG_FLOAT ||
                    state.current_tag == TAG_LONG || state.current_tag == TAG_DOUBLE)
                    width = 3'd4;
                else if (state.current_tag == TAG_MHANDLE && state.member_number == 16'd1)
                    width = 3'd1;
                else
                    width = 3'd2;
            end
            default:
                width = 3'd2;
        endcase
    end

    // byte assembly and shared arithmetic
    assign active      = !state.stopped && (state.phase < PH_DONE);
    assign count_inc   = state.byte_in_field + 3'd1;
    assign word        = {state.accumulator[23:0], data_byte};
    assign complete    = (count_inc >= width);
    assign member_inc  = state.member_number + 16'd1;
    assign attr_inc    = state.attr_number + 16'd1;
    assign rem_dec     = state.bytes_remaining - 32'd1;
    assign slot_step   = {1'b0, state.pool_slot} +
                         ((state.current_tag == TAG_LONG || state.current_tag == TAG_DOUBLE)
                          ? 17'd2 : 17'd1);
    assign pool_end    = (slot_step >= {1'b0, state.pool_total});
    assign tag_cnt     = tag_field_count(word[7:0]);
    assign cur_tag_cnt = tag_field_count({3'd0, state.current_tag});

    // attribute group of the current phase
    always_comb
    begin
        unique case (state.phase) inside
            PH_FHDR, PH_FANAME, PH_FALEN, PH_FABODY:
            begin
                a_base       = PH_FANAME;
                a_hdr        = PH_FHDR;
                a_next_count = PH_MCOUNT;
                a_sec        = SEC_FIELDS;
                a_class      = 1'b0;
            end
            PH_MHDR, PH_MANAME, PH_MALEN, PH_MABODY:
            begin
                a_base       = PH_MANAME;
                a_hdr        = PH_MHDR;
                a_next_count = PH_CCOUNT;
                a_sec        = SEC_METHODS;
                a_class      = 1'b0;
            end
            default:
            begin
                a_base       = PH_CANAME;
                a_hdr        = PH_CCOUNT;
                a_next_count = PH_DONE;
                a_sec        = SEC_CLASS_ATTR;
                a_class      = 1'b1;
            end
        endcase
    end

    // phase walk and record build
    always_comb
    begin
        state_next = state;
        rec_valid  = 1'b0;
        rec        = '{section: SEC_HEADER, kind: KIND_COUNT, position: 2'd0, value: word,
                       entry_index: 16'd0, attr_index: 16'd0, status: ST_OK,
                       done_res: 1'b0};

        if (active && !complete)
        begin
            state_next.accumulator   = word;
            state_next.byte_in_field = count_inc;
        end
        else if (active)
        begin
            state_next.accumulator   = 32'd0;
            state_next.byte_in_field = 3'd0;
            rec_valid                = 1'b1;

            unique case (state.phase)
                PH_MAGIC:
                begin
                    if (word != MAGIC_WORD)
                    begin
                        rec.kind           = KIND_ERROR;
                        rec.status         = ST_BAD_MAGIC;
                        state_next.stopped = 1'b1;
                    end
                    else
                    begin
                        rec.kind                 = KIND_U4;
                        state_next.member_number = 16'd1;
                        state_next.phase         = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    if (state.member_number < 16'd3)
                    begin
                        rec.kind                 = KIND_U2;
                        rec.position             = state.member_number[1:0];
                        state_next.member_number = member_inc;
                    end
                    else if (word < MIN_POOL)
                    begin
                        rec.section        = SEC_POOL;
                        rec.kind           = KIND_ERROR;
                        rec.status         = ST_POOL_SMALL;
                        state_next.stopped = 1'b1;
                    end
                    else
                    begin
                        rec.section              = SEC_POOL;
                        state_next.pool_total    = word[15:0];
                        state_next.pool_slot     = 16'd1;
                        state_next.member_number = 16'd0;
                        state_next.phase         = PH_TAG;
                    end
                end
                PH_TAG:
                begin
                    rec.section     = SEC_POOL;
                    rec.entry_index = state.pool_slot;
                    if (word[7:0] > MAX_TAG || tag_cnt == 2'd0)
                    begin
                        rec.kind           = KIND_ERROR;
                        rec.status         = ST_BAD_TAG;
                        state_next.stopped = 1'b1;
                    end
                    else
                    begin
                        rec.kind                 = KIND_TAG;
                        state_next.current_tag   = word[4:0];
                        state_next.member_number = 16'd1;
                        state_next.phase         = PH_PFIELD;
                    end
                end
                PH_PFIELD:
                begin
                    rec.section     = SEC_POOL;
                    rec.entry_index = state.pool_slot;
                    if (state.current_tag == TAG_UTF8)
                    begin
                        rec.kind                   = KIND_LENGTH;
                        rec.position               = 2'd1;
                        state_next.bytes_remaining = word;
                        if (word == 32'd0)
                        begin
                            state_next.pool_slot = slot_step[15:0];
                            if (pool_end)
                            begin
                                state_next.phase         = PH_CINFO;
                                state_next.member_number = 16'd0;
                            end
                            else
                                state_next.phase = PH_TAG;
                        end
                        else
                            state_next.phase = PH_PBODY;
                    end
                    else
                    begin
                        rec.kind     = (width == 3'd1) ? KIND_U1 :
                                       (width == 3'd2) ? KIND_U2 : KIND_U4;
                        rec.position = state.member_number[1:0];
                        if (state.member_number >= {14'd0, cur_tag_cnt})
                        begin
                            state_next.pool_slot = slot_step[15:0];
                            if (pool_end)
                            begin
                                state_next.phase         = PH_CINFO;
                                state_next.member_number = 16'd0;
                            end
                            else
                                state_next.phase = PH_TAG;
                        end
                        else
                            state_next.member_number = member_inc;
                    end
                end
                PH_PBODY:
                begin
                    rec.section                = SEC_POOL;
                    rec.kind                   = KIND_RAW;
                    rec.position               = 2'd2;
                    rec.entry_index            = state.pool_slot;
                    state_next.bytes_remaining = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        state_next.pool_slot = slot_step[15:0];
                        if (pool_end)
                        begin
                            state_next.phase         = PH_CINFO;
                            state_next.member_number = 16'd0;
                        end
                        else
                            state_next.phase = PH_TAG;
                    end
                end
                PH_CINFO:
                begin
                    rec.section              = SEC_CLASS_INFO;
                    rec.kind                 = KIND_U2;
                    rec.position             = state.member_number[1:0];
                    state_next.member_number = member_inc;
                    if (member_inc >= 16'd3)
                        state_next.phase = PH_ICOUNT;
                end
                PH_ICOUNT, PH_FCOUNT, PH_MCOUNT:
                begin
                    state_next.member_total  = word[15:0];
                    state_next.member_number = 16'd0;
                    state_next.attr_number   = 16'd0;
                    if (state.phase == PH_ICOUNT)
                    begin
                        rec.section      = SEC_IFACES;
                        state_next.phase = (word == 32'd0) ? PH_FCOUNT : PH_IFACE;
                    end
                    else if (state.phase == PH_FCOUNT)
                    begin
                        rec.section      = SEC_FIELDS;
                        state_next.phase = (word == 32'd0) ? PH_MCOUNT : PH_FHDR;
                    end
                    else
                    begin
                        rec.section      = SEC_METHODS;
                        state_next.phase = (word == 32'd0) ? PH_CCOUNT : PH_MHDR;
                    end
                end
                PH_IFACE:
                begin
                    rec.section              = SEC_IFACES;
                    rec.kind                 = KIND_U2;
                    rec.entry_index          = state.member_number;
                    state_next.member_number = member_inc;
                    if (member_inc == state.member_total)
                        state_next.phase = PH_FCOUNT;
                end
                PH_FHDR, PH_MHDR:
                begin
                    rec.section     = a_sec;
                    rec.entry_index = state.member_number;
                    if (state.attr_number < 16'd3)
                    begin
                        rec.kind               = KIND_U2;
                        rec.position           = state.attr_number[1:0];
                        state_next.attr_number = attr_inc;
                    end
                    else
                    begin
                        rec.position           = 2'd3;
                        state_next.attr_total  = word[15:0];
                        state_next.attr_number = 16'd0;
                        if (word == 32'd0)
                        begin
                            state_next.member_number = member_inc;
                            state_next.phase = (member_inc == state.member_total) ?
                                               a_next_count : a_hdr;
                        end
                        else
                            state_next.phase = a_base;
                    end
                end
                PH_CCOUNT:
                begin
                    rec.section            = SEC_CLASS_ATTR;
                    state_next.attr_total  = word[15:0];
                    state_next.attr_number = 16'd0;
                    state_next.phase       = (word == 32'd0) ? PH_DONE : PH_CANAME;
                end
                PH_FANAME, PH_MANAME, PH_CANAME:
                begin
                    rec.section      = a_sec;
                    rec.kind         = KIND_U2;
                    rec.entry_index  = a_class ? 16'd0 : state.member_number;
                    rec.attr_index   = state.attr_number;
                    state_next.phase = cfsp_phase_t'(state.phase + 5'd1);
                end
                PH_FALEN, PH_MALEN, PH_CALEN, PH_FABODY, PH_MABODY, PH_CABODY:
                begin
                    rec.section     = a_sec;
                    rec.entry_index = a_class ? 16'd0 : state.member_number;
                    rec.attr_index  = state.attr_number;
                    if (state.phase == PH_FALEN || state.phase == PH_MALEN ||
                        state.phase == PH_CALEN)
                    begin
                        rec.kind                   = KIND_LENGTH;
                        rec.position               = 2'd1;
                        state_next.bytes_remaining = word;
                    end
                    else
                    begin
                        rec.kind                   = KIND_RAW;
                        rec.position               = 2'd2;
                        state_next.bytes_remaining = rem_dec;
                    end
                    // body opens, or the attribute closes
                    if ((rec.kind == KIND_LENGTH) && (word != 32'd0))
                        state_next.phase = cfsp_phase_t'(state.phase + 5'd1);
                    else if ((rec.kind == KIND_LENGTH) || (rem_dec == 32'd0))
                    begin
                        state_next.attr_number = attr_inc;
                        if (attr_inc != state.attr_total)
                            state_next.phase = a_base;
                        else if (a_class)
                            state_next.phase = PH_DONE;
                        else
                        begin
                            state_next.member_number = member_inc;
                            state_next.attr_number   = 16'd0;
                            state_next.phase = (member_inc == state.member_total) ?
                                               a_next_count : a_hdr;
                        end
                    end
                end
                default:
                    rec_valid = 1'b0;
            endcase
        end

        rec.done_res = (state_next.phase == PH_DONE);
    end

endmodule

>>> rtl/class_file_stream_parser.sv
// top level of the class file stream parser
//
//  channel   dir  payload                                         beat
//  stream    in   data_byte                                       one file byte
//  records   out  section kind position value entry_index         one record
//                 attr_index status done_res
//
// one byte a cycle sustained while records are taken: a byte register feeds
// one step of logic that updates the parse state and loads the record register.
// a record is loaded into the record register when its last byte leaves the
// byte register through the step; a byte that completes no field gives no record.
// rst_n clears the parse state and both valid flags at once.
// a stalled record holds the step; the byte register drains as the
// record register frees, so ready follows the record sink.
// after a fault or after the last record every further byte is taken
// and dropped until reset.
module class_file_stream_parser (
    input  logic              clk,
    input  logic              rst_n,
    cfsp_byte_if.sink         stream,
    cfsp_rec_if.source        records
);
    import cfsp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    cfsp_state_t  state_reg;
    cfsp_state_t  state_next;
    logic         out_valid_reg;
    cfsp_record_t out_rec_reg;
    logic         step_rec_valid;
    cfsp_record_t step_rec;
    logic         advance;

    // step moves when a byte waits and the record slot is free or freeing
    assign advance      = in_valid_reg && (!out_valid_reg || records.ready);
    assign stream.ready = !in_valid_reg || advance;

    // byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (stream.ready)
            in_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
            in_byte_reg <= stream.data_byte;
    end

    cfsp_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .state_next (state_next),
        .rec_valid  (step_rec_valid),
        .rec        (step_rec)
    );

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // record register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step_rec_valid;
        else if (records.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_rec_valid)
            out_rec_reg <= step_rec;
    end

    // record beat out
    assign records.valid       = out_valid_reg;
    assign records.section     = out_rec_reg.section;
    assign records.kind        = out_rec_reg.kind;
    assign records.position    = out_rec_reg.position;
    assign records.value       = out_rec_reg.value;
    assign records.entry_index = out_rec_reg.entry_index;
    assign records.attr_index  = out_rec_reg.attr_index;
    assign records.status      = out_rec_reg.status;
    assign records.done_res    = out_rec_reg.done_res;

endmodule

>>> rtl/cfsp_checker.sv
// port checker for the class file stream parser, bound to the top level
`include "class_file_stream_parser_assert.svh"

module cfsp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rec_valid,
    input  logic        rec_ready,
    input  logic [2:0]  section,
    input  logic [2:0]  kind,
    input  logic [31:0] value,
    input  logic [1:0]  status,
    input  logic        done_res
);
    import cfsp_pkg::*;

    // a stalled record beat stays and keeps its value
    `CFSP_ASSERT_NEXT(a_rec_hold, rec_valid && !rec_ready, rec_valid && $stable(value), "record beat changed while stalled")

    // error records and only error records carry a fault status
    `CFSP_ASSERT_NOW(a_err_status, rec_valid, (kind == KIND_ERROR) == (status != ST_OK), "kind and status disagree")

    // the final record closes the class attributes with no fault
    `CFSP_ASSERT_NOW(a_done_sec, rec_valid && done_res, (section == SEC_CLASS_ATTR) && (status == ST_OK), "final record outside class attributes")

    // nothing follows a fault or the final record
    `CFSP_ASSERT_NEXT(a_stop_quiet, rec_valid && rec_ready && (done_res || (kind == KIND_ERROR)), !rec_valid, "record after parsing stopped")

endmodule

bind class_file_stream_parser cfsp_checker u_cfsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (records.valid),
    .rec_ready (records.ready),
    .section   (records.section),
    .kind      (records.kind),
    .value     (records.value),
    .status    (records.status),
    .done_res  (records.done_res)
);
